[src/aabb_affine_transform_macros.svh]
// Assertion macros for the box transform RTL, included by the top level.
// Depends on a clock named clock and a reset named reset in the including scope.
`ifndef AABB_AFFINE_TRANSFORM_MACROS_SVH
`define AABB_AFFINE_TRANSFORM_MACROS_SVH

// Checked outside of reset.
`define AAT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every edge, reset included.
`define AAT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[src/aat_pkg.sv]
// Shared widths, register codes and payload types for the box transform.
// No dependencies.
`timescale 1ns / 1ps

package aat_pkg;

   localparam int AXES           = 3;
   localparam int COORD_WIDTH    = 32;
   localparam int COEF_WIDTH     = 16;
   localparam int FRAC_SHIFT     = COEF_WIDTH - 2;
   localparam int PROD_WIDTH     = COORD_WIDTH + COEF_WIDTH;
   localparam int SPROD_WIDTH    = PROD_WIDTH - FRAC_SHIFT;
   // translation plus three scaled products
   localparam int SUM_WIDTH      = SPROD_WIDTH + 2;
   localparam int ROW_WIDTH      = 48;
   localparam int CSR_DATA_WIDTH = 64;
   localparam int CSR_ADDR_WIDTH = 6;
   localparam int CSR_IDX_LSB    = 3;

   typedef enum logic [CSR_ADDR_WIDTH-CSR_IDX_LSB-1:0] {
      CSR_ROW_X,
      CSR_ROW_Y,
      CSR_ROW_Z,
      CSR_SHIFT_X,
      CSR_SHIFT_Y,
      CSR_SHIFT_Z
   } csr_idx_type;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [COEF_WIDTH-1:0]  coef_type;

   typedef struct packed {
      logic [AXES-1:0][ROW_WIDTH-1:0]   row;    // row[i]: coefficients applied to input axis i
      logic [AXES-1:0][COORD_WIDTH-1:0] shift;
   } cfg_type;

   typedef struct packed {
      logic [AXES-1:0][COORD_WIDTH-1:0] lo;
      logic [AXES-1:0][COORD_WIDTH-1:0] hi;
   } box_type;

   // [i][j]: input axis i scaled into output axis j
   typedef struct packed {
      logic [AXES-1:0][AXES-1:0][SPROD_WIDTH-1:0] lo;
      logic [AXES-1:0][AXES-1:0][SPROD_WIDTH-1:0] hi;
   } prod_type;

endpackage

[src/aabb_affine_transform.sv]
// Top level of the 3x4 affine bounding-box transform: input register and stage wiring.
// Depends on aat_pkg, aat_csr, aat_mul, aat_acc and the assertion macro header.
//
//   channel   ports                 direction   payload
//   req       req_valid/req_ready   in          req_lo_*, req_hi_* (Q16.16)
//   rsp       rsp_valid/rsp_ready   out         rsp_out_lo_*, rsp_out_hi_* (Q16.16, saturated)
//   csr       psel/penable/pwrite   in/out      paddr, pwdata, prdata, pready
//
// One box per cycle sustained while rsp is not stalled. The stages are the input register,
// the product register behind eighteen 32x16 multipliers, and the result register.
// Each stage holds its transaction while the next one is full and stalled; a stalled rsp backs up
// to req_ready only once all three stages hold data.
// Synchronous reset empties the pipeline and loads the identity transform.
`timescale 1ns / 1ps
`include "aabb_affine_transform_macros.svh"

module aabb_affine_transform import aat_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  coord_type                 req_lo_x,
   input  coord_type                 req_lo_y,
   input  coord_type                 req_lo_z,
   input  coord_type                 req_hi_x,
   input  coord_type                 req_hi_y,
   input  coord_type                 req_hi_z,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output coord_type                 rsp_out_lo_x,
   output coord_type                 rsp_out_lo_y,
   output coord_type                 rsp_out_lo_z,
   output coord_type                 rsp_out_hi_x,
   output coord_type                 rsp_out_hi_y,
   output coord_type                 rsp_out_hi_z,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   cfg_type  cfg;
   box_type  box_in;
   box_type  box_ff;
   logic     in_v_in;
   logic     in_v_ff;
   logic     mul_in_ready;
   logic     mul_valid;
   logic     acc_in_ready;
   prod_type prod;
   box_type  result;

   assign box_in.lo[0] = req_lo_x;
   assign box_in.lo[1] = req_lo_y;
   assign box_in.lo[2] = req_lo_z;
   assign box_in.hi[0] = req_hi_x;
   assign box_in.hi[1] = req_hi_y;
   assign box_in.hi[2] = req_hi_z;

   assign req_ready = !in_v_ff || mul_in_ready;
   assign in_v_in   = req_ready ? req_valid : in_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else begin
         in_v_ff <= in_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         box_ff <= box_in;
      end
   end

   aat_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   aat_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_v_ff),
      .in_ready  (mul_in_ready),
      .box       (box_ff),
      .cfg       (cfg),
      .out_valid (mul_valid),
      .out_ready (acc_in_ready),
      .prod      (prod)
   );

   aat_acc u_acc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_valid),
      .in_ready  (acc_in_ready),
      .prod      (prod),
      .cfg       (cfg),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .result    (result)
   );

   assign rsp_out_lo_x = result.lo[0];
   assign rsp_out_lo_y = result.lo[1];
   assign rsp_out_lo_z = result.lo[2];
   assign rsp_out_hi_x = result.hi[0];
   assign rsp_out_hi_y = result.hi[1];
   assign rsp_out_hi_z = result.hi[2];

   `AAT_ASSERT_ALWAYS(a_reset_empties, reset |=> !in_v_ff && !mul_valid && !rsp_valid, "pipeline not empty after reset")
   `AAT_ASSERT(a_accept_lands, req_valid && req_ready |=> in_v_ff, "accepted transaction lost at input register")
   `AAT_ASSERT(a_full_backpressure, in_v_ff && mul_valid && rsp_valid && !rsp_ready |-> !req_ready, "input taken while pipeline full and stalled")
   `AAT_ASSERT(a_box_ordered, rsp_valid |-> $signed(rsp_out_lo_x) <= $signed(rsp_out_hi_x) && $signed(rsp_out_lo_y) <= $signed(rsp_out_hi_y) && $signed(rsp_out_lo_z) <= $signed(rsp_out_hi_z), "result minimum exceeds maximum")

endmodule

[src/aat_csr.sv]
// APB-style register file holding the coefficient rows and translations.
// Depends on aat_pkg.
`timescale 1ns / 1ps

module aat_csr import aat_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output cfg_type                   cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   csr_idx_type idx;
   logic        wr_en;

   assign idx    = csr_idx_type'(paddr[CSR_ADDR_WIDTH-1:CSR_IDX_LSB]);
   assign wr_en  = psel & penable & pwrite & pready;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            CSR_ROW_X:   cfg_in.row[0]   = pwdata[ROW_WIDTH-1:0];
            CSR_ROW_Y:   cfg_in.row[1]   = pwdata[ROW_WIDTH-1:0];
            CSR_ROW_Z:   cfg_in.row[2]   = pwdata[ROW_WIDTH-1:0];
            CSR_SHIFT_X: cfg_in.shift[0] = pwdata[COORD_WIDTH-1:0];
            CSR_SHIFT_Y: cfg_in.shift[1] = pwdata[COORD_WIDTH-1:0];
            CSR_SHIFT_Z: cfg_in.shift[2] = pwdata[COORD_WIDTH-1:0];
            default: ;  // beyond the map: dropped
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         CSR_ROW_X:   prdata = CSR_DATA_WIDTH'(cfg_ff.row[0]);
         CSR_ROW_Y:   prdata = CSR_DATA_WIDTH'(cfg_ff.row[1]);
         CSR_ROW_Z:   prdata = CSR_DATA_WIDTH'(cfg_ff.row[2]);
         CSR_SHIFT_X: prdata = CSR_DATA_WIDTH'(cfg_ff.shift[0]);
         CSR_SHIFT_Y: prdata = CSR_DATA_WIDTH'(cfg_ff.shift[1]);
         CSR_SHIFT_Z: prdata = CSR_DATA_WIDTH'(cfg_ff.shift[2]);
         default:     prdata = '0;
      endcase
   end

   // identity at reset: 1.0 on the diagonal, no translation
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < AXES; j++) begin
            cfg_ff.row[j]   <= ROW_WIDTH'(1) << (FRAC_SHIFT + j * COEF_WIDTH);
            cfg_ff.shift[j] <= '0;
         end
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[src/aat_mul.sv]
// Product stage: all eighteen corner-by-coefficient products, floored to Q.16.
// Depends on aat_pkg.
`timescale 1ns / 1ps

module aat_mul import aat_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  box_type  box,
   input  cfg_type  cfg,
   output logic     out_valid,
   input  logic     out_ready,
   output prod_type prod
);

   coef_type                      coef  [AXES][AXES];
   logic signed [PROD_WIDTH-1:0]  p_lo  [AXES][AXES];
   logic signed [PROD_WIDTH-1:0]  p_hi  [AXES][AXES];
   prod_type                      prod_in;
   prod_type                      prod_ff;
   logic                          v_in;
   logic                          v_ff;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         for (int j = 0; j < AXES; j++) begin
            coef[i][j] = $signed(cfg.row[i][j*COEF_WIDTH +: COEF_WIDTH]);
            p_lo[i][j] = $signed(box.lo[i]) * coef[i][j];
            p_hi[i][j] = $signed(box.hi[i]) * coef[i][j];
            // dropping the low bits of a two's complement value floors it
            prod_in.lo[i][j] = p_lo[i][j][PROD_WIDTH-1:FRAC_SHIFT];
            prod_in.hi[i][j] = p_hi[i][j][PROD_WIDTH-1:FRAC_SHIFT];
         end
      end
   end

   assign in_ready  = !v_ff || out_ready;
   assign v_in      = in_ready ? in_valid : v_ff;
   assign out_valid = v_ff;
   assign prod      = prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         prod_ff <= prod_in;
      end
   end

endmodule

[src/aat_acc.sv]
// Sum stage: min/max pick per term, add translation, saturate, result register.
// Depends on aat_pkg.
`timescale 1ns / 1ps

module aat_acc import aat_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  prod_type prod,
   input  cfg_type  cfg,
   output logic     out_valid,
   input  logic     out_ready,
   output box_type  result
);

   logic signed [SUM_WIDTH-1:0] s_lo [AXES];
   logic signed [SUM_WIDTH-1:0] s_hi [AXES];
   box_type                     res_in;
   box_type                     res_ff;
   logic                        v_in;
   logic                        v_ff;

   function automatic logic [COORD_WIDTH-1:0] saturate(input logic signed [SUM_WIDTH-1:0] v);
      logic [SUM_WIDTH-COORD_WIDTH:0] top;
      top = v[SUM_WIDTH-1:COORD_WIDTH-1];
      if (top == '0 || top == '1) begin
         return v[COORD_WIDTH-1:0];
      end else if (v[SUM_WIDTH-1]) begin
         return {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
         return {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
   endfunction

   always_comb begin
      for (int j = 0; j < AXES; j++) begin
         s_lo[j] = SUM_WIDTH'($signed(cfg.shift[j]));
         s_hi[j] = SUM_WIDTH'($signed(cfg.shift[j]));
         for (int i = 0; i < AXES; i++) begin
            // a negative coefficient swaps which corner gives the extreme
            if ($signed(prod.lo[i][j]) >= $signed(prod.hi[i][j])) begin
               s_lo[j] = s_lo[j] + SUM_WIDTH'($signed(prod.hi[i][j]));
               s_hi[j] = s_hi[j] + SUM_WIDTH'($signed(prod.lo[i][j]));
            end else begin
               s_lo[j] = s_lo[j] + SUM_WIDTH'($signed(prod.lo[i][j]));
               s_hi[j] = s_hi[j] + SUM_WIDTH'($signed(prod.hi[i][j]));
            end
         end
         res_in.lo[j] = saturate(s_lo[j]);
         res_in.hi[j] = saturate(s_hi[j]);
      end
   end

   assign in_ready  = !v_ff || out_ready;
   assign v_in      = in_ready ? in_valid : v_ff;
   assign out_valid = v_ff;
   assign result    = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         res_ff <= res_in;
      end
   end

endmodule
